>>> src/rbps_pkg.sv
// Shared types, codes and constants of the fan remote button press sequencer.
`timescale 1ns / 1ps

package rbps_pkg;

    // Queue of waiting presses.
    localparam int QUEUE_DEPTH = 20;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = QCNT_W + 1;

    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QSUM_W-1:0] QSUM_WRAP = QSUM_W'(QUEUE_DEPTH);

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 16;
    localparam int PIN_W    = 6;
    localparam int CFG_PIN_W = 7;
    localparam int MAXB_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Timing and defaults.
    localparam logic signed [VALUE_W-1:0] PRESS_MS      = 16'sd200;
    localparam logic signed [VALUE_W-1:0] DEFAULT_SPEED = 16'sd3;
    localparam logic signed [CFG_PIN_W-1:0] PIN_NONE    = -7'sd1;
    localparam logic [MAXB_W-1:0] MAXB_RESET            = 15'd3;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 3'd0,
        CMD_SET_BRIGHT  = 3'd1,
        CMD_TURN_LIGHT  = 3'd2,
        CMD_SET_SPEED   = 3'd3,
        CMD_TURN_FAN    = 3'd4,
        CMD_HOLD_LIGHT  = 3'd5
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_PIN      = 3'd0,
        REG_LIGHT_OFF_PIN  = 3'd1,
        REG_FAN_FAST_PIN   = 3'd2,
        REG_FAN_MEDIUM_PIN = 3'd3,
        REG_FAN_SLOW_PIN   = 3'd4,
        REG_FAN_OFF_PIN    = 3'd5,
        REG_MAX_BRIGHTNESS = 3'd6
    } cfg_reg_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic                        is_tick;
        logic                        press_req;
        logic [PIN_W-1:0]            pin;
        logic signed [VALUE_W-1:0]   time_ms;
        logic                        light_on;
        logic signed [VALUE_W-1:0]   brightness;
        logic                        fan_on;
        logic signed [VALUE_W-1:0]   speed;
    } op_t;

endpackage

>>> src/rbps_cmd_if.sv
// Command channel: one command item with its value.
`timescale 1ns / 1ps

interface rbps_cmd_if;
    logic                                    valid;
    logic                                    ready;
    logic [rbps_pkg::CMD_W-1:0]              cmd;
    logic signed [rbps_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> src/rbps_result_if.sv
// Result channel: pin events and light and fan status of one item.
`timescale 1ns / 1ps

interface rbps_result_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    release_valid;
    logic [rbps_pkg::PIN_W-1:0]              release_pin;
    logic                                    press_valid;
    logic [rbps_pkg::PIN_W-1:0]              press_pin;
    logic                                    queue_overflow;
    logic                                    light_on;
    logic signed [rbps_pkg::VALUE_W-1:0]     brightness;
    logic                                    fan_on;
    logic signed [rbps_pkg::VALUE_W-1:0]     speed;

    modport source (output valid, output release_valid, output release_pin,
                    output press_valid, output press_pin, output queue_overflow,
                    output light_on, output brightness, output fan_on, output speed,
                    input ready);
    modport sink   (input valid, input release_valid, input release_pin,
                    input press_valid, input press_pin, input queue_overflow,
                    input light_on, input brightness, input fan_on, input speed,
                    output ready);
endinterface

>>> src/rbps_front.sv
// Front part: configuration registers, light and fan status, command classification.
`timescale 1ns / 1ps

module rbps_front (
    input  logic                                clk,
    input  logic                                rst_n,
    rbps_cmd_if.sink                            cmd_ch,
    input  logic                                cfg_we,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                push_valid,
    input  logic                                push_ready,
    output rbps_pkg::op_t                       push_op
);

    logic signed [rbps_pkg::CFG_PIN_W-1:0] light_pin_reg;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] light_off_pin_reg;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] fan_fast_pin_reg;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] fan_medium_pin_reg;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] fan_slow_pin_reg;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] fan_off_pin_reg;
    logic [rbps_pkg::MAXB_W-1:0]           max_brightness_reg;

    logic                                  light_state_reg, light_state_next;
    logic                                  fan_state_reg, fan_state_next;
    logic signed [rbps_pkg::VALUE_W-1:0]   bright_level_reg, bright_level_next;
    logic signed [rbps_pkg::VALUE_W-1:0]   speed_level_reg, speed_level_next;

    logic                                  accept;
    logic                                  req;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] sel_pin;
    logic signed [rbps_pkg::VALUE_W-1:0]   sel_time;
    logic signed [rbps_pkg::VALUE_W-1:0]   fan_s;
    logic signed [rbps_pkg::CFG_PIN_W-1:0] light_off_sel;
    logic                                  is_tick;
    logic signed [rbps_pkg::VALUE_W-1:0]   val;

    assign val          = cmd_ch.value;
    assign accept       = cmd_ch.valid && push_ready;
    assign cmd_ch.ready = push_ready;
    assign push_valid   = cmd_ch.valid;

    // The light off command falls back to the light button when no off button exists.
    assign light_off_sel = light_off_pin_reg[rbps_pkg::CFG_PIN_W-1] ? light_pin_reg
                                                                    : light_off_pin_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pin_reg      <= rbps_pkg::PIN_NONE;
            light_off_pin_reg  <= rbps_pkg::PIN_NONE;
            fan_fast_pin_reg   <= rbps_pkg::PIN_NONE;
            fan_medium_pin_reg <= rbps_pkg::PIN_NONE;
            fan_slow_pin_reg   <= rbps_pkg::PIN_NONE;
            fan_off_pin_reg    <= rbps_pkg::PIN_NONE;
            max_brightness_reg <= rbps_pkg::MAXB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbps_pkg::REG_LIGHT_PIN:      light_pin_reg      <= cfg_data[6:0];
                rbps_pkg::REG_LIGHT_OFF_PIN:  light_off_pin_reg  <= cfg_data[6:0];
                rbps_pkg::REG_FAN_FAST_PIN:   fan_fast_pin_reg   <= cfg_data[6:0];
                rbps_pkg::REG_FAN_MEDIUM_PIN: fan_medium_pin_reg <= cfg_data[6:0];
                rbps_pkg::REG_FAN_SLOW_PIN:   fan_slow_pin_reg   <= cfg_data[6:0];
                rbps_pkg::REG_FAN_OFF_PIN:    fan_off_pin_reg    <= cfg_data[6:0];
                rbps_pkg::REG_MAX_BRIGHTNESS: max_brightness_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Speed requested by a speed or fan command; turning the fan on reuses a positive
    // stored speed and otherwise the default speed.
    always_comb
    begin
        if (cmd_ch.cmd == rbps_pkg::CMD_SET_SPEED || val == '0)
            fan_s = val;
        else if (!speed_level_reg[rbps_pkg::VALUE_W-1] && speed_level_reg != '0)
            fan_s = speed_level_reg;
        else
            fan_s = rbps_pkg::DEFAULT_SPEED;
    end

    // Command decode: status update and the press that the command asks for.
    always_comb
    begin
        light_state_next  = light_state_reg;
        fan_state_next    = fan_state_reg;
        bright_level_next = bright_level_reg;
        speed_level_next  = speed_level_reg;
        req               = 1'b0;
        sel_pin           = light_pin_reg;
        sel_time          = rbps_pkg::PRESS_MS;
        is_tick           = 1'b0;
        case (cmd_ch.cmd)
            rbps_pkg::CMD_TICK:
            begin
                is_tick = 1'b1;
            end
            rbps_pkg::CMD_SET_BRIGHT:
            begin
                if (val == '0)
                begin
                    light_state_next = 1'b0;
                    req              = 1'b1;
                    sel_pin          = light_off_sel;
                end
                else if (!val[rbps_pkg::VALUE_W-1])
                begin
                    light_state_next  = 1'b1;
                    bright_level_next = val;
                    req               = 1'b1;
                end
            end
            rbps_pkg::CMD_TURN_LIGHT:
            begin
                if (val == '0)
                begin
                    light_state_next = 1'b0;
                    req              = 1'b1;
                    sel_pin          = light_off_sel;
                end
                else
                begin
                    light_state_next  = 1'b1;
                    bright_level_next = {1'b0, max_brightness_reg};
                    req               = 1'b1;
                end
            end
            rbps_pkg::CMD_SET_SPEED, rbps_pkg::CMD_TURN_FAN:
            begin
                if (fan_s == '0)
                begin
                    fan_state_next = 1'b0;
                    req            = 1'b1;
                    sel_pin        = fan_off_pin_reg;
                end
                else
                begin
                    fan_state_next   = 1'b1;
                    speed_level_next = fan_s;
                    if (fan_s == 16'sd1)
                    begin
                        req     = 1'b1;
                        sel_pin = fan_slow_pin_reg;
                    end
                    else if (fan_s == 16'sd2)
                    begin
                        req     = 1'b1;
                        sel_pin = fan_medium_pin_reg;
                    end
                    else if (fan_s == 16'sd3)
                    begin
                        req     = 1'b1;
                        sel_pin = fan_fast_pin_reg;
                    end
                end
            end
            rbps_pkg::CMD_HOLD_LIGHT:
            begin
                req      = 1'b1;
                sel_time = val;
            end
            default:
            begin
            end
        endcase
    end

    // A disabled (negative) pin asks for no press at all.
    always_comb
    begin
        push_op            = '0;
        push_op.is_tick    = is_tick;
        push_op.press_req  = req && !sel_pin[rbps_pkg::CFG_PIN_W-1];
        push_op.pin        = sel_pin[rbps_pkg::PIN_W-1:0];
        push_op.time_ms    = sel_time;
        push_op.light_on   = light_state_next;
        push_op.brightness = light_state_next ? bright_level_next : '0;
        push_op.fan_on     = fan_state_next;
        push_op.speed      = fan_state_next ? speed_level_next : '0;
    end

    // Status registers change only with an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_state_reg  <= 1'b0;
            fan_state_reg    <= 1'b0;
            bright_level_reg <= '0;
            speed_level_reg  <= '0;
        end
        else if (accept)
        begin
            light_state_reg  <= light_state_next;
            fan_state_reg    <= fan_state_next;
            bright_level_reg <= bright_level_next;
            speed_level_reg  <= speed_level_next;
        end
    end

endmodule

>>> src/rbps_op_fifo.sv
// Two-entry queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module rbps_op_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rbps_pkg::op_t   push_op,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rbps_pkg::op_t   pop_op
);

    rbps_pkg::op_t  slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> src/rbps_back.sv
// Back part: held button timer, queue of waiting presses and the result register.
`timescale 1ns / 1ps

module rbps_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    output logic            op_ready,
    input  rbps_pkg::op_t   op,
    rbps_result_if.source   result_ch
);

    logic                                   held_active_reg, held_active_next;
    logic [rbps_pkg::PIN_W-1:0]             held_pin_reg, held_pin_next;
    logic [rbps_pkg::VALUE_W-1:0]           hold_left_reg, hold_left_next;
    logic [rbps_pkg::QPTR_W-1:0]            head_reg, head_next;
    logic [rbps_pkg::QCNT_W-1:0]            count_reg, count_next;
    logic [rbps_pkg::PIN_W-1:0]             qpin_reg [rbps_pkg::QUEUE_DEPTH];
    logic signed [rbps_pkg::VALUE_W-1:0]    qtime_reg [rbps_pkg::QUEUE_DEPTH];

    logic                                   take;
    logic                                   enq;
    logic [rbps_pkg::QSUM_W-1:0]            slot_sum;
    logic [rbps_pkg::QSUM_W-1:0]            slot_wrap;
    logic [rbps_pkg::QPTR_W-1:0]            enq_slot;
    logic                                   start;
    logic [rbps_pkg::PIN_W-1:0]             start_pin;
    logic signed [rbps_pkg::VALUE_W-1:0]    start_time;
    logic                                   rel;
    logic [rbps_pkg::PIN_W-1:0]             rel_pin;
    logic                                   ovf;

    logic                                   out_valid_reg;
    logic                                   rel_valid_reg;
    logic [rbps_pkg::PIN_W-1:0]             rel_pin_reg;
    logic                                   press_valid_reg;
    logic [rbps_pkg::PIN_W-1:0]             press_pin_reg;
    logic                                   ovf_reg;
    logic                                   light_on_reg;
    logic signed [rbps_pkg::VALUE_W-1:0]    brightness_reg;
    logic                                   fan_on_reg;
    logic signed [rbps_pkg::VALUE_W-1:0]    speed_reg;

    // An item is taken whenever the result register is free or being emptied.
    assign op_ready = !out_valid_reg || result_ch.ready;
    assign take     = op_valid && op_ready;

    // Tail slot of the press queue: head plus count, wrapped once.
    assign slot_sum  = rbps_pkg::QSUM_W'(head_reg) + rbps_pkg::QSUM_W'(count_reg);
    assign slot_wrap = (slot_sum >= rbps_pkg::QSUM_WRAP) ? slot_sum - rbps_pkg::QSUM_WRAP
                                                         : slot_sum;
    assign enq_slot  = slot_wrap[rbps_pkg::QPTR_W-1:0];

    // Tick handling, queuing and the start of a press.
    always_comb
    begin
        held_active_next = held_active_reg;
        held_pin_next    = held_pin_reg;
        hold_left_next   = hold_left_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        enq              = 1'b0;
        start            = 1'b0;
        start_pin        = op.pin;
        start_time       = op.time_ms;
        rel              = 1'b0;
        rel_pin          = '0;
        ovf              = 1'b0;
        if (op.is_tick)
        begin
            if (held_active_reg)
            begin
                if (hold_left_reg > 16'd1)
                begin
                    hold_left_next = hold_left_reg - 16'd1;
                end
                else
                begin
                    rel              = 1'b1;
                    rel_pin          = held_pin_reg;
                    held_active_next = 1'b0;
                    hold_left_next   = '0;
                    if (count_reg != '0)
                    begin
                        start      = 1'b1;
                        start_pin  = qpin_reg[head_reg];
                        start_time = qtime_reg[head_reg];
                        head_next  = (head_reg == rbps_pkg::QPTR_LAST) ? '0
                                                                       : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
        end
        else if (op.press_req)
        begin
            if (held_active_reg)
            begin
                if (count_reg == rbps_pkg::QCNT_FULL)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    enq        = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                start = 1'b1;
            end
        end
        // A negative hold time counts as zero.
        if (start)
        begin
            held_active_next = 1'b1;
            held_pin_next    = start_pin;
            hold_left_next   = start_time[rbps_pkg::VALUE_W-1] ? '0 : start_time;
        end
    end

    // Press queue storage.
    always_ff @(posedge clk)
    begin
        if (take && enq)
        begin
            qpin_reg[enq_slot]  <= op.pin;
            qtime_reg[enq_slot] <= op.time_ms;
        end
    end

    // Held button and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_active_reg <= 1'b0;
            held_pin_reg    <= '0;
            hold_left_reg   <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
        end
        else if (take)
        begin
            held_active_reg <= held_active_next;
            held_pin_reg    <= held_pin_next;
            hold_left_reg   <= hold_left_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rel_valid_reg   <= rel;
            rel_pin_reg     <= rel_pin;
            press_valid_reg <= start;
            press_pin_reg   <= start ? start_pin : '0;
            ovf_reg         <= ovf;
            light_on_reg    <= op.light_on;
            brightness_reg  <= op.brightness;
            fan_on_reg      <= op.fan_on;
            speed_reg       <= op.speed;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.release_valid  = rel_valid_reg;
    assign result_ch.release_pin    = rel_pin_reg;
    assign result_ch.press_valid    = press_valid_reg;
    assign result_ch.press_pin      = press_pin_reg;
    assign result_ch.queue_overflow = ovf_reg;
    assign result_ch.light_on       = light_on_reg;
    assign result_ch.brightness     = brightness_reg;
    assign result_ch.fan_on         = fan_on_reg;
    assign result_ch.speed          = speed_reg;

endmodule

>>> src/remote_button_press_sequencer.sv
// Top level of the fan remote button press sequencer.
`timescale 1ns / 1ps

// Commands arrive on cmd_ch (valid/ready): light and fan commands, button holds and
// one-millisecond ticks. Each accepted item yields exactly one result item on
// result_ch with the release and press pin events, the overflow flag and the
// light and fan status after that item.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is
// idle; register indexes follow the register list, index 7 is ignored.
// An accepted item passes through the two-entry queue and the back part's update into the
// result register, where it is presented until the receiver takes it.
// Throughput: one item per cycle while the receiver takes results; every item takes
// one pass through the front decode and one back-part held-button and press-queue update.
// A two-entry queue sits between the front and back parts, and the result register
// frees itself in the cycle it is taken, so a new item is accepted while a result waits.
// When the receiver stalls, results stay in the output register, the inner queue
// fills and cmd_ch.ready drops after at most two more items; nothing is lost.
// Reset clears the light and fan status, the held button and the press queue and
// sets all pins to disabled and max_brightness to 3; no clearing pass is needed.
module remote_button_press_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    rbps_cmd_if.sink                            cmd_ch,
    rbps_result_if.source                       result_ch,
    input  logic                                cfg_we,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic            push_valid;
    logic            push_ready;
    rbps_pkg::op_t   push_op;
    logic            pop_valid;
    logic            pop_ready;
    rbps_pkg::op_t   pop_op;

    // Front part: decode and status.
    rbps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Decoupling queue.
    rbps_op_fifo u_op_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back part: button timing and results.
    rbps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (pop_valid),
        .op_ready   (pop_ready),
        .op         (pop_op),
        .result_ch  (result_ch)
    );

endmodule

>>> tb/tb_top.sv
// Testbench of the fan remote button press sequencer with its own status and press predictor.
`timescale 1ns / 1ps

module tb_top;
    import rbps_pkg::*;

    localparam int NUM_REGS      = int'(REG_MAX_BRIGHTNESS) + 1;
    localparam int NUM_PINS      = int'(REG_FAN_OFF_PIN) + 1;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 150;
    localparam int LONG_HOLD     = 48;
    localparam int TAIL_CYCLES   = 10;
    localparam int REPORT_LIMIT  = 40;
    localparam int CYCLE_LIMIT   = 50000;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // One result item: pin events and light and fan status.
    typedef struct packed {
        logic                      release_valid;
        logic [PIN_W-1:0]          release_pin;
        logic                      press_valid;
        logic [PIN_W-1:0]          press_pin;
        logic                      queue_overflow;
        logic                      light_on;
        logic signed [VALUE_W-1:0] brightness;
        logic                      fan_on;
        logic signed [VALUE_W-1:0] speed;
    } status_t;

    // A press that waits for the held button to be released.
    typedef struct {
        logic [PIN_W-1:0]          pin;
        logic signed [VALUE_W-1:0] ms;
    } waiting_press_t;

    // Predicts the pin events and status of every accepted command and checks the results.
    class button_status_board;
        logic signed [CFG_PIN_W-1:0] pin_cfg [NUM_PINS];
        logic [MAXB_W-1:0]           max_bright;
        bit                          held;
        logic [PIN_W-1:0]            held_pin;
        logic [VALUE_W-1:0]          hold_left;
        waiting_press_t              waiting [$];
        logic signed [VALUE_W-1:0]   bright_lvl;
        logic signed [VALUE_W-1:0]   speed_lvl;
        bit                          light;
        bit                          fan;
        status_t                     now;
        status_t                     expected_status [$];
        int unsigned                 errors;

        function new();
            foreach (pin_cfg[i])
                pin_cfg[i] = PIN_NONE;
            max_bright = MAXB_RESET;
            held       = 1'b0;
            held_pin   = '0;
            hold_left  = '0;
            bright_lvl = '0;
            speed_lvl  = '0;
            light      = 1'b0;
            fan        = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAX_BRIGHTNESS)
                max_bright = data[MAXB_W-1:0];
            else if (int'(idx) < NUM_PINS)
                pin_cfg[int'(idx)] = data[CFG_PIN_W-1:0];
        endfunction

        function logic signed [CFG_PIN_W-1:0] pin_of(cfg_reg_t r);
            return pin_cfg[int'(r)];
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void start_press(logic [PIN_W-1:0] pin, logic signed [VALUE_W-1:0] ms);
            held      = 1'b1;
            held_pin  = pin;
            hold_left = (ms > 0) ? ms : '0;
            now.press_valid = 1'b1;
            now.press_pin   = pin;
        endfunction

        // A disabled pin is skipped; while a button is held the press waits or is dropped.
        function void request_press(logic signed [CFG_PIN_W-1:0] pin,
                                    logic signed [VALUE_W-1:0] ms);
            waiting_press_t entry;
            if (pin < 0)
                return;
            if (held)
            begin
                if (waiting.size() >= QUEUE_DEPTH)
                    now.queue_overflow = 1'b1;
                else
                begin
                    entry.pin = pin[PIN_W-1:0];
                    entry.ms  = ms;
                    waiting.push_back(entry);
                end
            end
            else
                start_press(pin[PIN_W-1:0], ms);
        endfunction

        function void set_level(logic signed [VALUE_W-1:0] lvl);
            if (lvl == 0)
            begin
                light = 1'b0;
                request_press(pin_of(REG_LIGHT_OFF_PIN) < 0 ? pin_of(REG_LIGHT_PIN)
                                                            : pin_of(REG_LIGHT_OFF_PIN),
                              PRESS_MS);
            end
            else if (lvl > 0)
            begin
                light      = 1'b1;
                bright_lvl = lvl;
                request_press(pin_of(REG_LIGHT_PIN), PRESS_MS);
            end
        endfunction

        // Speeds other than zero to three change the status but press nothing.
        function void set_speed(logic signed [VALUE_W-1:0] s);
            if (s == 0)
            begin
                fan = 1'b0;
                request_press(pin_of(REG_FAN_OFF_PIN), PRESS_MS);
            end
            else
            begin
                fan       = 1'b1;
                speed_lvl = s;
                case (s)
                    16'sd1:  request_press(pin_of(REG_FAN_SLOW_PIN), PRESS_MS);
                    16'sd2:  request_press(pin_of(REG_FAN_MEDIUM_PIN), PRESS_MS);
                    16'sd3:  request_press(pin_of(REG_FAN_FAST_PIN), PRESS_MS);
                    default: ;
                endcase
            end
        endfunction

        function void take_command(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v);
            waiting_press_t entry;
            now = '0;
            case (c)
                CMD_TICK:
                    if (held)
                    begin
                        if (hold_left > 1)
                            hold_left--;
                        else
                        begin
                            now.release_valid = 1'b1;
                            now.release_pin   = held_pin;
                            held      = 1'b0;
                            hold_left = '0;
                            if (waiting.size() != 0)
                            begin
                                entry = waiting.pop_front();
                                start_press(entry.pin, entry.ms);
                            end
                        end
                    end
                CMD_SET_BRIGHT:
                    set_level(v);
                CMD_TURN_LIGHT:
                    if (v == 0)
                        set_level('0);
                    else
                    begin
                        bright_lvl = VALUE_W'(max_bright);
                        light      = 1'b1;
                        request_press(pin_of(REG_LIGHT_PIN), PRESS_MS);
                    end
                CMD_SET_SPEED:
                    set_speed(v);
                CMD_TURN_FAN:
                    if (v == 0)
                        set_speed('0);
                    else
                        set_speed(speed_lvl > 0 ? speed_lvl : DEFAULT_SPEED);
                CMD_HOLD_LIGHT:
                    request_press(pin_of(REG_LIGHT_PIN), v);
                default: ;
            endcase
            now.light_on   = light;
            now.brightness = light ? bright_lvl : '0;
            now.fan_on     = fan;
            now.speed      = fan ? speed_lvl : '0;
            expected_status.push_back(now);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result item with no command waiting, actual %p",
                             $time, got);
                return;
            end
            want = expected_status.pop_front();
            compare_field("release_valid", want.release_valid, got.release_valid);
            compare_field("release_pin", want.release_pin, got.release_pin);
            compare_field("press_valid", want.press_valid, got.press_valid);
            compare_field("press_pin", want.press_pin, got.press_pin);
            compare_field("queue_overflow", want.queue_overflow, got.queue_overflow);
            compare_field("light_on", want.light_on, got.light_on);
            compare_field("brightness", want.brightness, got.brightness);
            compare_field("fan_on", want.fan_on, got.fan_on);
            compare_field("speed", want.speed, got.speed);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [CFG_DATA_W-1:0] cfg_image [NUM_REGS];
    bit                    idle_on;
    bit                    hold_off_req;
    int unsigned           commands_sent;
    int unsigned           cycle_count = 0;
    button_status_board    sb;

    rbps_cmd_if    cmd_ch ();
    rbps_result_if result_ch ();

    remote_button_press_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("remote_button_press_sequencer: mismatch");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Check every accepted result item.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_status('{release_valid:  result_ch.release_valid,
                              release_pin:    result_ch.release_pin,
                              press_valid:    result_ch.press_valid,
                              press_pin:      result_ch.press_pin,
                              queue_overflow: result_ch.queue_overflow,
                              light_on:       result_ch.light_on,
                              brightness:     result_ch.brightness,
                              fan_on:         result_ch.fan_on,
                              speed:          result_ch.speed});
    end

    // Offer one command item and hold it until it is taken; then maybe pause.
    task automatic send_item(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v);
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= c;
        cmd_ch.value <= v;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        sb.take_command(c, v);
        if (c < CMD_UNUSED_LO)
            commands_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= cfg_image[i];
            @(posedge clk);
            sb.write_reg(cfg_reg_t'(i), cfg_image[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [CFG_PIN_W-1:0] random_pin();
        if ($urandom_range(0, 5) == 0)
            return PIN_NONE;
        return CFG_PIN_W'($urandom_range(0, 63));
    endfunction

    // Mostly short holds so that queued presses keep moving.
    function automatic logic signed [VALUE_W-1:0] hold_time();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return VALUE_W'(int'($urandom_range(0, 6)) - 2);
        else if (r < 9)
            return VALUE_W'($urandom_range(5, 60));
        return {1'b1, 15'($urandom)};
    endfunction

    // One random command; a burst leaves out ticks so that presses pile up.
    task automatic random_item(bit burst);
        int unsigned               pick;
        logic [CMD_W-1:0]          c;
        logic signed [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (burst)
            pick = 40 + pick % 60;
        v = VALUE_W'($urandom);
        if (pick < 40)
            c = CMD_TICK;
        else if (pick < 50)
        begin
            c = CMD_SET_BRIGHT;
            if (pick % 2 == 0)
                v = VALUE_W'($urandom_range(0, 3));
        end
        else if (pick < 58)
        begin
            c = CMD_TURN_LIGHT;
            if (pick % 2 == 0)
                v = '0;
        end
        else if (pick < 68)
        begin
            c = CMD_SET_SPEED;
            if (pick % 3 != 0)
                v = VALUE_W'($urandom_range(0, 4));
        end
        else if (pick < 76)
        begin
            c = CMD_TURN_FAN;
            if (pick % 2 == 0)
                v = '0;
        end
        else if (pick < 97)
        begin
            c = CMD_HOLD_LIGHT;
            v = hold_time();
        end
        else
            c = CMD_CMD_PICK_UNUSED();
        send_item(c, v);
    endtask

    function automatic logic [CMD_W-1:0] CMD_CMD_PICK_UNUSED();
        return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    endfunction

    // Segments of press bursts, mixed commands and tick runs.
    task automatic random_phase(int unsigned budget, bit quiet);
        int unsigned first;
        int unsigned n;
        first = commands_sent;
        while (commands_sent - first < budget)
        begin
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(18, 26)) random_item(1'b1);
                1: repeat ($urandom_range(10, 30)) random_item(1'b0);
                default:
                begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(195, 205)
                                                    : $urandom_range(1, 30);
                    repeat (n) send_item(CMD_TICK, VALUE_W'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        idle_on       = 1'b0;
        hold_off_req  = 1'b0;
        commands_sent = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_LIGHT_PIN;
        cfg_data     <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.cmd   <= CMD_TICK;
        cmd_ch.value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: every pin disabled, so nothing is pressed.
        send_item(CMD_SET_BRIGHT, 16'sd5);
        send_item(CMD_TURN_FAN, 16'sd1);
        send_item(CMD_HOLD_LIGHT, 16'sd10);
        send_item(CMD_TICK, 16'sd0);
        settle();

        // Pin extremes, no separate light off button, largest brightness.
        cfg_image[REG_LIGHT_PIN]      = CFG_DATA_W'(7'sd0);
        cfg_image[REG_LIGHT_OFF_PIN]  = CFG_DATA_W'(PIN_NONE);
        cfg_image[REG_FAN_FAST_PIN]   = CFG_DATA_W'(7'sd63);
        cfg_image[REG_FAN_MEDIUM_PIN] = CFG_DATA_W'(7'sd1);
        cfg_image[REG_FAN_SLOW_PIN]   = CFG_DATA_W'(7'sd62);
        cfg_image[REG_FAN_OFF_PIN]    = CFG_DATA_W'(7'sd2);
        cfg_image[REG_MAX_BRIGHTNESS] = '1;
        program_regs();

        // Every command with value extremes; presses queue behind the first one.
        send_item(CMD_SET_BRIGHT, 16'sh7FFF);
        send_item(CMD_SET_BRIGHT, 16'sh8000);
        send_item(CMD_SET_BRIGHT, 16'sd0);
        send_item(CMD_TURN_LIGHT, 16'sd1);
        send_item(CMD_TURN_LIGHT, 16'sd0);
        send_item(CMD_SET_SPEED, 16'sd1);
        send_item(CMD_SET_SPEED, 16'sd2);
        send_item(CMD_SET_SPEED, 16'sd3);
        send_item(CMD_SET_SPEED, 16'sd0);
        send_item(CMD_SET_SPEED, 16'sh8000);
        send_item(CMD_TURN_FAN, 16'sd0);
        send_item(CMD_TURN_FAN, 16'sd1);
        send_item(CMD_SET_SPEED, 16'sh7FFF);
        send_item(CMD_TURN_FAN, -16'sd1);
        send_item(CMD_HOLD_LIGHT, 16'sh8000);
        send_item(CMD_HOLD_LIGHT, 16'sd0);
        send_item(CMD_HOLD_LIGHT, 16'sd1);
        send_item(CMD_HOLD_LIGHT, 16'sh7FFF);
        send_item(CMD_UNUSED_LO, 16'sh5555);
        send_item(CMD_UNUSED_HI, -16'sh5556);
        send_item(CMD_TICK, 16'sh7FFF);
        send_item(CMD_TICK, 16'sh8000);
        settle();

        // Random phases, each with its own configuration; a held button and
        // queued presses carry over, since only the decode reads the registers.
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            for (int i = 0; i < NUM_PINS; i++)
                cfg_image[i] = CFG_DATA_W'(random_pin());
            if (k == 0)
                cfg_image[REG_LIGHT_OFF_PIN] = CFG_DATA_W'($urandom_range(0, 63));
            if (k == 0)
                cfg_image[REG_MAX_BRIGHTNESS] = '0;
            else if (k == 1)
                cfg_image[REG_MAX_BRIGHTNESS] = '1;
            else
                cfg_image[REG_MAX_BRIGHTNESS] = CFG_DATA_W'($urandom);
            program_regs();
            if (k == 1)
                hold_off_req = 1'b1;
            random_phase(PHASE_ITEMS, k == RANDOM_PHASES - 1);
            settle();
        end

        idle_on = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("remote_button_press_sequencer: match");
        else
            $display("remote_button_press_sequencer: mismatch");
        $finish;
    end

endmodule
